FILE: hdl/sfp_pkg.sv
// Shared constants and types for the square-free part / least factor sieve block.
package sfp_pkg;

    // Number of table entries; values at or above it cannot be factored.
    localparam int TABLE_SIZE = 65536;

    // Table address width.
    localparam int AW = $clog2(TABLE_SIZE);

    // Width of the input value and of the result.
    localparam int VAL_W = 16;

    // Common width that holds both an input value and a table address.
    localparam int XW = (AW > VAL_W) ? AW : VAL_W;

    // Sieve prime counter: i*i < TABLE_SIZE needs about half the address bits.
    localparam int IW = (AW + 1) / 2 + 1;

    // Table entry: least prime factor and the cofactor left after one division.
    typedef struct packed {
        logic [AW-1:0] spf;
        logic [AW-1:0] cof;
    } entry_t;

    localparam int ENT_W = 2 * AW;

endpackage

FILE: hdl/sfp_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
module sfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hdl/squarefree_part_spf_sieve_core.sv
// Top level: square-free part of a 16-bit value through a least-prime-factor table.
//
// Usage
//   Input channel : value / value_valid / value_stall. A transfer happens at a
//                   rising edge with value_valid high and value_stall low.
//   Output channel: squarefree_part / squarefree_part_valid / squarefree_part_stall,
//                   same rule, the downstream side drives the stall.
//   Reset (rst_n low, async) clears all control. Afterwards the block builds its
//   table in one RAM: an init sweep writes every entry with {self, cofactor 1},
//   then an Eratosthenes sieve over primes p*p < TABLE_SIZE marks each multiple
//   j >= p*p that no smaller prime has marked with {p, j/p}, one multiple per
//   cycle. value_stall stays high until the whole build is done.
//   Per item: a first table read at the value, then one step per prime factor
//   occurrence (the cofactor read out of the RAM is the next read address,
//   so the RAM read port sets the pace), a step to fold in the last prime and
//   a step to hand over to the output register. Values 0 and 1 give 1; values
//   at or above TABLE_SIZE give 0. Both skip the factoring and go to hand-over.
//   The result sits in an output register; while the receiver stalls, the block
//   finishes the next item and waits with it until the register frees up.
module squarefree_part_spf_sieve_core
    import sfp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [VAL_W-1:0] value,
    input  logic             value_valid,
    output logic             value_stall,
    output logic [VAL_W-1:0] squarefree_part,
    output logic             squarefree_part_valid,
    input  logic             squarefree_part_stall
);

    // Controller states
    localparam logic [2:0] S_INIT  = 3'd0;  // init sweep
    localparam logic [2:0] S_OUTER = 3'd1;  // next sieve candidate
    localparam logic [2:0] S_OCHK  = 3'd2;  // is candidate still prime
    localparam logic [2:0] S_INNER = 3'd3;  // mark multiples
    localparam logic [2:0] S_IDLE  = 3'd4;  // ready for a transfer
    localparam logic [2:0] S_FACT  = 3'd5;  // one factor per cycle
    localparam logic [2:0] S_TAIL  = 3'd6;  // fold last prime
    localparam logic [2:0] S_DONE  = 3'd7;  // move to output register

    logic [2:0]       state_reg, state_next;
    logic [AW:0]      cnt_reg, cnt_next;       // init sweep address
    logic [IW-1:0]    i_reg, i_next;           // sieve prime
    logic [AW:0]      j_reg, j_next;           // current multiple
    logic [AW-1:0]    k_reg, k_next;           // j / i
    logic             pend_reg, pend_next;     // read in flight in the sieve
    logic [AW-1:0]    paddr_reg, paddr_next;
    logic [AW-1:0]    pk_reg, pk_next;
    logic [VAL_W-1:0] res_reg, res_next;
    logic [AW-1:0]    last_reg, last_next;
    logic             odd_reg, odd_next;
    logic [VAL_W-1:0] out_reg, out_next;
    logic             out_valid_reg, out_valid_next;

    logic             we;
    logic [AW-1:0]    waddr, raddr;
    entry_t           wentry, rentry;
    logic [ENT_W-1:0] rdata;

    logic [2*IW-1:0]     isq;
    logic [VAL_W+AW-1:0] prod;
    logic [XW-1:0]       value_x;
    logic                accept;
    logic                out_free;

    sfp_ram #(
        .WIDTH (ENT_W),
        .DEPTH (TABLE_SIZE)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wentry),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign rentry   = entry_t'(rdata);
    assign isq      = (2*IW)'(i_reg) * (2*IW)'(i_reg);
    assign prod     = (VAL_W+AW)'(res_reg) * (VAL_W+AW)'(last_reg);
    assign value_x  = XW'(value);
    assign accept   = value_valid && (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || !squarefree_part_stall;

    assign value_stall           = (state_reg != S_IDLE);
    assign squarefree_part       = out_reg;
    assign squarefree_part_valid = out_valid_reg;

    // RAM read address: the cofactor just read is the next address while factoring.
    always_comb
    begin
        case (state_reg)
            S_OUTER: raddr = AW'(i_reg);
            S_INNER: raddr = j_reg[AW-1:0];
            S_FACT:  raddr = rentry.cof;
            default: raddr = value_x[AW-1:0];
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        pend_next      = 1'b0;
        paddr_next     = paddr_reg;
        pk_next        = pk_reg;
        res_next       = res_reg;
        last_next      = last_reg;
        odd_next       = odd_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && squarefree_part_stall;
        we             = 1'b0;
        waddr          = cnt_reg[AW-1:0];
        wentry.spf     = cnt_reg[AW-1:0];
        wentry.cof     = AW'(1);

        case (state_reg)
            S_INIT:
            begin
                we       = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (32'(cnt_reg) == 32'(TABLE_SIZE - 1))
                begin
                    i_next     = IW'(2);
                    state_next = S_OUTER;
                end
            end

            S_OUTER:
            begin
                if (32'(isq) >= 32'(TABLE_SIZE))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_OCHK;
                end
            end

            S_OCHK:
            begin
                if (rentry.spf == AW'(i_reg))
                begin
                    j_next     = (AW+1)'(isq);
                    k_next     = AW'(i_reg);
                    state_next = S_INNER;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_OUTER;
                end
            end

            S_INNER:
            begin
                // Write back the multiple read last cycle if nothing marked it yet.
                if (pend_reg && (rentry.spf == paddr_reg))
                begin
                    we         = 1'b1;
                    waddr      = paddr_reg;
                    wentry.spf = AW'(i_reg);
                    wentry.cof = pk_reg;
                end
                if (32'(j_reg) < 32'(TABLE_SIZE))
                begin
                    pend_next  = 1'b1;
                    paddr_next = j_reg[AW-1:0];
                    pk_next    = k_reg;
                    j_next     = j_reg + (AW+1)'(i_reg);
                    k_next     = k_reg + 1'b1;
                end
                else if (!pend_reg)
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_OUTER;
                end
            end

            S_IDLE:
            begin
                if (accept)
                begin
                    res_next  = VAL_W'(1);
                    last_next = '0;
                    odd_next  = 1'b0;
                    if (32'(value) >= 32'(TABLE_SIZE))
                    begin
                        res_next   = '0;
                        state_next = S_DONE;
                    end
                    else if (value < VAL_W'(2))
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_FACT;
                    end
                end
            end

            S_FACT:
            begin
                // Primes come out in nondecreasing order: a new prime closes the old run.
                if (rentry.spf != last_reg)
                begin
                    if (odd_reg)
                    begin
                        res_next = prod[VAL_W-1:0];
                    end
                    last_next = rentry.spf;
                    odd_next  = 1'b1;
                end
                else
                begin
                    odd_next = !odd_reg;
                end
                if (rentry.cof == AW'(1))
                begin
                    state_next = S_TAIL;
                end
            end

            S_TAIL:
            begin
                if (odd_reg)
                begin
                    res_next = prod[VAL_W-1:0];
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            cnt_reg       <= '0;
            i_reg         <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            i_reg         <= i_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        j_reg     <= j_next;
        k_reg     <= k_next;
        paddr_reg <= paddr_next;
        pk_reg    <= pk_next;
        res_reg   <= res_next;
        last_reg  <= last_next;
        odd_reg   <= odd_next;
        out_reg   <= out_next;
    end

endmodule

FILE: sim/tb_squarefree_part_spf_sieve_core.sv
// Testbench for squarefree_part_spf_sieve_core: random and directed values against a predictor.
module tb_squarefree_part_spf_sieve_core
    import sfp_pkg::*;
();

    // Input transfers before the sender stops and lets the block run dry.
    localparam int DRAIN_AT      = 900;
    // First long receiver hold-off, reckoned in accepted inputs, and its spacing.
    localparam int HOLD_FIRST_AT = 400;
    localparam int HOLD_SPACING  = 900;
    localparam int HOLD_CYCLES   = 400;
    localparam int RANDOM_ITEMS  = 1780;
    localparam int SETTLE_CYCLES = 50;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic [VAL_W-1:0] value = '0;
    logic             value_valid = 1'b0;
    logic             value_stall;
    logic [VAL_W-1:0] squarefree_part;
    logic             squarefree_part_valid;
    logic             squarefree_part_stall = 1'b0;

    squarefree_part_spf_sieve_core dut (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .value                 (value),
        .value_valid           (value_valid),
        .value_stall           (value_stall),
        .squarefree_part       (squarefree_part),
        .squarefree_part_valid (squarefree_part_valid),
        .squarefree_part_stall (squarefree_part_stall)
    );

    always #1 clk = ~clk;

    // Values waiting to be offered, and the square-free parts owed by the block.
    logic [VAL_W-1:0] values_to_send[$];
    logic [VAL_W-1:0] sqf_expected[$];

    int n_total    = 0;
    int n_issued   = 0;
    int n_accepted = 0;
    int n_errors   = 0;
    bit in_xfer    = 1'b0;

    // Append one value to the stimulus list.
    function automatic void queue_value(input logic [VAL_W-1:0] v);
        values_to_send.insert(values_to_send.size(), v);
    endfunction

    // Square-free part by trial division: every prime that divides x an odd
    // number of times goes into the product. 0 and 1 come out as 1; a value the
    // table cannot hold comes out as 0.
    function automatic logic [VAL_W-1:0] squarefree_of_value(input logic [VAL_W-1:0] v);
        int unsigned x;
        int unsigned p;
        int unsigned prod;
        bit          odd;
        if (int'(v) >= TABLE_SIZE)
            return '0;
        x = 32'(v);
        prod = 1;
        for (p = 2; p * p <= x; p++)
        begin
            odd = 1'b0;
            while (x % p == 0)
            begin
                x = x / p;
                odd = ~odd;
            end
            if (odd)
                prod = prod * p;
        end
        // Whatever is left above 1 is a prime with exponent one.
        if (x > 1)
            prod = prod * x;
        return prod[VAL_W-1:0];
    endfunction

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Random value, shaped so that many have deep factorizations and repeated primes.
    function automatic logic [VAL_W-1:0] random_value();
        int unsigned small_primes[25] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41,
                                          43, 47, 53, 59, 61, 67, 71, 73, 79, 83, 89, 97};
        int unsigned edge_values[10] = '{0, 1, 2, 3, 65535, 65534, 65521, 63001, 65025,
                                         59049};
        int unsigned x;
        int unsigned p;
        int unsigned r;
        int          mode;
        mode = $urandom_range(0, 99);
        if (mode < 40)
            return VAL_W'($urandom_range(0, 65535));
        if (mode < 70)
        begin
            // product of small primes, duplicates likely
            x = 1;
            repeat ($urandom_range(1, 16))
            begin
                p = small_primes[$urandom_range(0, 24)];
                if (x * p <= 65535)
                    x = x * p;
            end
            return x[VAL_W-1:0];
        end
        if (mode < 85)
        begin
            // a square times a cofactor
            r = $urandom_range(2, 255);
            x = r * r * $urandom_range(1, 65535 / (r * r));
            return x[VAL_W-1:0];
        end
        if (mode < 93)
            return VAL_W'(edge_values[$urandom_range(0, 9)]);
        x = 1 << $urandom_range(0, 15);
        return x[VAL_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Sender: offers queued values, holds a stalled transfer steady, then
    // idles a random gap. Once DRAIN_AT values have gone out it waits for
    // every owed result before going on.
    // ------------------------------------------------------------------
    int gap_left   = 0;
    int burst_left = 0;

    always @(negedge clk)
    begin
        logic             next_valid;
        logic [VAL_W-1:0] next_value;
        next_valid = value_valid;
        next_value = value;
        if (rst_n)
        begin
            if (value_valid && !in_xfer)
            begin
                // stalled: payload stays put
            end
            else
            begin
                next_valid = 1'b0;
                if (gap_left > 0)
                    gap_left--;
                else if (n_issued == DRAIN_AT &&
                         (n_accepted != n_issued || sqf_expected.size() != 0))
                begin
                    // draining: hold off until the block is empty
                end
                else if (values_to_send.size() > 0)
                begin
                    next_valid = 1'b1;
                    next_value = values_to_send.pop_front();
                    n_issued++;
                    // bursts of back-to-back transfers between idle stretches
                    if (burst_left > 0)
                    begin
                        burst_left--;
                        gap_left = 0;
                    end
                    else if ($urandom_range(0, 99) < 3)
                    begin
                        burst_left = $urandom_range(20, 60);
                        gap_left = 0;
                    end
                    else
                        gap_left = pick_gap();
                end
            end
        end
        value_valid <= next_valid;
        value       <= next_value;
    end

    // ------------------------------------------------------------------
    // Receiver: random stall pattern with runs of no stall, plus a long
    // hold-off every HOLD_SPACING inputs so the block fills and backs up
    // into the input channel.
    // ------------------------------------------------------------------
    int hold_left    = 0;
    int next_hold_at = HOLD_FIRST_AT;
    int stall_left   = 0;
    int run_left     = 0;

    always @(negedge clk)
    begin
        logic next_stall;
        next_stall = squarefree_part_stall;
        if (hold_left > 0)
        begin
            next_stall = 1'b1;
            hold_left--;
        end
        else if (n_accepted >= next_hold_at)
        begin
            next_stall = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            next_hold_at += HOLD_SPACING;
        end
        else if (stall_left > 0)
        begin
            next_stall = 1'b1;
            stall_left--;
        end
        else if (run_left > 0)
        begin
            next_stall = 1'b0;
            run_left--;
        end
        else
        begin
            next_stall = 1'b0;
            stall_left = pick_gap();
            run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150)
                                                   : $urandom_range(0, 6);
        end
        squarefree_part_stall <= next_stall;
    end

    // ------------------------------------------------------------------
    // Monitor: at each rising edge, log accepted inputs as owed results and
    // compare every result transfer with the oldest one owed.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        logic [VAL_W-1:0] want;
        if (rst_n)
        begin
            in_xfer <= value_valid && !value_stall;
            if (value_valid && !value_stall)
            begin
                sqf_expected.insert(sqf_expected.size(), squarefree_of_value(value));
                n_accepted++;
            end
            if (squarefree_part_valid && !squarefree_part_stall)
            begin
                if (sqf_expected.size() == 0)
                begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("unexpected result %0d, nothing owed", squarefree_part);
                end
                else
                begin
                    want = sqf_expected.pop_front();
                    if (squarefree_part !== want)
                    begin
                        n_errors++;
                        if (n_errors <= 10)
                            $display("squarefree_part mismatch: expected %0d, got %0d",
                                     want, squarefree_part);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus, reset and end of run.
    // ------------------------------------------------------------------
    initial
    begin
        int i;
        // Directed: zero and one, field extremes, the largest prime, pure
        // squares, deep powers, and products of many distinct primes.
        queue_value(16'd0);
        queue_value(16'd1);
        queue_value(16'd2);
        queue_value(16'd3);
        queue_value(16'd4);
        queue_value(16'd12);
        queue_value(16'd16);
        queue_value(16'd360);
        queue_value(16'd30030);
        queue_value(16'd32768);
        queue_value(16'd49152);
        queue_value(16'd59049);
        queue_value(16'd63001);
        queue_value(16'd64009);
        queue_value(16'd65025);
        queue_value(16'd65280);
        queue_value(16'd65521);
        queue_value(16'd65534);
        queue_value(16'd65535);
        queue_value(16'h5555);
        queue_value(16'hAAAA);
        for (i = 0; i < RANDOM_ITEMS; i++)
            queue_value(random_value());
        n_total = values_to_send.size();

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // The first transfer waits for the table build.
        while (n_accepted < n_total || sqf_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (n_errors == 0 && sqf_expected.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog: fails the run if the build plus every item at its slowest gaps and stalls has not finished in time.
    initial
    begin
        #4000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
